// ----- hw/rtl/ptzfm_pkg.sv -----
// Package for the PTZ view to fisheye mapper: widths, register codes,
// reset values and the constant tables (view cosines and sines, CORDIC arctangents).
// No dependencies.
package ptzfm_pkg;

  localparam int PAN_VIEWS  = 8;
  localparam int TILT_VIEWS = 4;

  localparam int W_CFG_IDX  = 3;
  localparam int W_CFG_DATA = 24;

  localparam int W_RAY = 18;  // Q1.16 ray coordinate
  localparam int W_W   = 42;  // rotated ray component
  localparam int W_VEC = 44;  // vectoring CORDIC datapath
  localparam int W_ANG = 26;  // angle in 2^-16 degree
  localparam int W_ROT = 38;  // rotation CORDIC datapath
  localparam int W_PQ  = 18;  // pan in Q9.8 degrees

  localparam int DIV_W     = 35;
  localparam int DIV_STEPS = 35;

  localparam logic [15:0] GAIN_INV = 16'd39797;
  localparam logic signed [W_ANG-1:0] DEG90 = 26'sd5898240;

  localparam logic [23:0] RST_INV_FOCAL  = 24'd29183;
  localparam logic [11:0] RST_CENTER_X2  = 12'd639;
  localparam logic [11:0] RST_CENTER_Y2  = 12'd359;
  localparam logic [10:0] RST_OUT_RADIUS = 11'd500;
  localparam logic [7:0]  RST_TILT_LIMIT = 8'd107;

  typedef enum logic [W_CFG_IDX-1:0] {
    REG_INV_FOCAL  = 3'd0,
    REG_CENTER_X2  = 3'd1,
    REG_CENTER_Y2  = 3'd2,
    REG_OUT_RADIUS = 3'd3,
    REG_TILT_LIMIT = 3'd4
  } reg_idx_t;

  function automatic logic signed [10:0] pan_cos(input logic [2:0] i);
    unique case (i)
      3'd0: return 11'sd1000;
      3'd1: return 11'sd707;
      3'd2: return 11'sd0;
      3'd3: return -11'sd707;
      3'd4: return -11'sd1000;
      3'd5: return -11'sd707;
      3'd6: return 11'sd0;
      3'd7: return 11'sd707;
    endcase
  endfunction

  function automatic logic signed [10:0] pan_sin(input logic [2:0] i);
    unique case (i)
      3'd0: return 11'sd0;
      3'd1: return 11'sd707;
      3'd2: return 11'sd1000;
      3'd3: return 11'sd707;
      3'd4: return 11'sd0;
      3'd5: return -11'sd707;
      3'd6: return -11'sd1000;
      3'd7: return -11'sd707;
    endcase
  endfunction

  function automatic logic signed [10:0] tilt_cos(input logic [3:0] i);
    unique case (i)
      4'd0:  return 11'sd1000;
      4'd1:  return 11'sd892;
      4'd2:  return 11'sd594;
      4'd3:  return 11'sd169;
      4'd4:  return -11'sd292;
      4'd5:  return -11'sd691;
      4'd6:  return -11'sd942;
      4'd7:  return -11'sd992;
      4'd8:  return -11'sd829;
      4'd9:  return -11'sd488;
      4'd10: return -11'sd43;
      4'd11: return 11'sd410;
      4'd12: return 11'sd777;
      4'd13: return 11'sd977;
      4'd14: return 11'sd968;
      4'd15: return 11'sd751;
    endcase
  endfunction

  function automatic logic signed [10:0] tilt_sin(input logic [3:0] i);
    unique case (i)
      4'd0:  return 11'sd0;
      4'd1:  return -11'sd450;
      4'd2:  return -11'sd803;
      4'd3:  return -11'sd985;
      4'd4:  return -11'sd956;
      4'd5:  return -11'sd722;
      4'd6:  return -11'sd333;
      4'd7:  return 11'sd126;
      4'd8:  return 11'sd559;
      4'd9:  return 11'sd872;
      4'd10: return 11'sd999;
      4'd11: return 11'sd911;
      4'd12: return 11'sd629;
      4'd13: return 11'sd212;
      4'd14: return -11'sd250;
      4'd15: return -11'sd659;
    endcase
  endfunction

  // atan(2^-i) in 2^-16 degree.
  function automatic logic [22:0] atan_tab(input int i);
    case (i)
      0:  return 23'd2949120;
      1:  return 23'd1740967;
      2:  return 23'd919879;
      3:  return 23'd466945;
      4:  return 23'd234379;
      5:  return 23'd117304;
      6:  return 23'd58666;
      7:  return 23'd29335;
      8:  return 23'd14668;
      9:  return 23'd7334;
      10: return 23'd3667;
      11: return 23'd1833;
      12: return 23'd917;
      13: return 23'd458;
      14: return 23'd229;
      15: return 23'd115;
      16: return 23'd57;
      17: return 23'd29;
      18: return 23'd14;
      19: return 23'd7;
      20: return 23'd4;
      21: return 23'd2;
      22: return 23'd1;
      default: return 23'd0;
    endcase
  endfunction

endpackage

// ----- hw/rtl/ptzfm_in_if.sv -----
// Input channel of the fisheye mapper: one source pixel per beat.
// No dependencies.
interface ptzfm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  pan_index;
  logic [1:0]  tilt_index;
  logic [9:0]  src_x;
  logic [9:0]  src_y;
  logic [23:0] pixel;

  modport source (output valid, pan_index, tilt_index, src_x, src_y, pixel, input ready);
  modport sink   (input valid, pan_index, tilt_index, src_x, src_y, pixel, output ready);
endinterface

// ----- hw/rtl/ptzfm_out_if.sv -----
// Output channel of the fisheye mapper: one mapped pixel per beat.
// No dependencies.
interface ptzfm_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] dest_x;
  logic [11:0] dest_y;
  logic        inside_res;
  logic [23:0] pixel_out;

  modport source (output valid, dest_x, dest_y, inside_res, pixel_out, input ready);
  modport sink   (input valid, dest_x, dest_y, inside_res, pixel_out, output ready);
endinterface

// ----- hw/rtl/ptzfm_cordic_vec.sv -----
// Pipelined vectoring CORDIC: atan2(y, x) and gain-scaled magnitude,
// one iteration per stage. Depends on ptzfm_pkg.
module ptzfm_cordic_vec #(
  parameter int W     = 44,
  parameter int STEPS = 16,
  parameter int SW    = 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_vld,
  input  logic signed [W-1:0]                x,
  input  logic signed [W-1:0]                y,
  input  logic [SW-1:0]                      side_in,
  output logic                               out_vld,
  output logic signed [W-1:0]                mag,
  output logic signed [ptzfm_pkg::W_ANG-1:0] ang,
  output logic [SW-1:0]                      side_out
);

  localparam int ZW = ptzfm_pkg::W_ANG;

  logic                 vld  [STEPS+1];
  logic signed [W-1:0]  xr   [STEPS+1];
  logic signed [W-1:0]  yr   [STEPS+1];
  logic signed [ZW-1:0] zr   [STEPS+1];
  logic                 zero [STEPS+1];
  logic [SW-1:0]        sd   [STEPS+1];

  logic signed [W-1:0]  x0, y0;
  logic signed [ZW-1:0] z0;

  // Bring a left half-plane vector into the right half-plane first.
  always_comb begin
    if (x[W-1]) begin
      if (!y[W-1]) begin
        x0 = y;
        y0 = -x;
        z0 = ptzfm_pkg::DEG90;
      end else begin
        x0 = -y;
        y0 = x;
        z0 = -ptzfm_pkg::DEG90;
      end
    end else begin
      x0 = x;
      y0 = y;
      z0 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xr[0]   <= x0;
      yr[0]   <= y0;
      zr[0]   <= z0;
      zero[0] <= (x == '0) && (y == '0);
      sd[0]   <= side_in;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [W-1:0]  xs, ys;
    logic signed [ZW-1:0] at;

    assign xs = xr[i] >>> i;
    assign ys = yr[i] >>> i;
    assign at = $signed({3'b000, ptzfm_pkg::atan_tab(i)});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!yr[i][W-1]) begin
          xr[i+1] <= xr[i] + ys;
          yr[i+1] <= yr[i] - xs;
          zr[i+1] <= zr[i] + at;
        end else begin
          xr[i+1] <= xr[i] - ys;
          yr[i+1] <= yr[i] + xs;
          zr[i+1] <= zr[i] - at;
        end
        zero[i+1] <= zero[i];
        sd[i+1]   <= sd[i];
      end
    end
  end

  // A zero vector reports angle and magnitude zero.
  assign out_vld  = vld[STEPS];
  assign mag      = (zero[STEPS] || xr[STEPS][W-1]) ? '0 : xr[STEPS];
  assign ang      = zero[STEPS] ? '0 : zr[STEPS];
  assign side_out = sd[STEPS];

endmodule

// ----- hw/rtl/ptzfm_cordic_rot.sv -----
// Pipelined rotation CORDIC: rotates (x0, 0) by an angle in 2^-16 degree,
// one iteration per stage. Depends on ptzfm_pkg.
module ptzfm_cordic_rot #(
  parameter int W     = 38,
  parameter int STEPS = 16,
  parameter int SW    = 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_vld,
  input  logic signed [W-1:0]                x0,
  input  logic signed [ptzfm_pkg::W_ANG-1:0] ang,
  input  logic [SW-1:0]                      side_in,
  output logic                               out_vld,
  output logic signed [W-1:0]                x_out,
  output logic signed [W-1:0]                y_out,
  output logic [SW-1:0]                      side_out
);

  localparam int ZW = ptzfm_pkg::W_ANG;

  logic                 vld [STEPS+1];
  logic signed [W-1:0]  xr  [STEPS+1];
  logic signed [W-1:0]  yr  [STEPS+1];
  logic signed [ZW-1:0] zr  [STEPS+1];
  logic [SW-1:0]        sd  [STEPS+1];

  logic signed [W-1:0]  xi, yi;
  logic signed [ZW-1:0] zi;

  // Angles beyond a right angle start from the rotated axis.
  always_comb begin
    priority if (ang > ptzfm_pkg::DEG90) begin
      xi = '0;
      yi = x0;
      zi = ang - ptzfm_pkg::DEG90;
    end else if (ang < -ptzfm_pkg::DEG90) begin
      xi = '0;
      yi = -x0;
      zi = ang + ptzfm_pkg::DEG90;
    end else begin
      xi = x0;
      yi = '0;
      zi = ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xr[0] <= xi;
      yr[0] <= yi;
      zr[0] <= zi;
      sd[0] <= side_in;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [W-1:0]  xs, ys;
    logic signed [ZW-1:0] at;

    assign xs = xr[i] >>> i;
    assign ys = yr[i] >>> i;
    assign at = $signed({3'b000, ptzfm_pkg::atan_tab(i)});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!zr[i][ZW-1]) begin
          xr[i+1] <= xr[i] - ys;
          yr[i+1] <= yr[i] + xs;
          zr[i+1] <= zr[i] - at;
        end else begin
          xr[i+1] <= xr[i] + ys;
          yr[i+1] <= yr[i] - xs;
          zr[i+1] <= zr[i] + at;
        end
        sd[i+1] <= sd[i];
      end
    end
  end

  assign out_vld  = vld[STEPS];
  assign x_out    = xr[STEPS];
  assign y_out    = yr[STEPS];
  assign side_out = sd[STEPS];

endmodule

// ----- hw/rtl/ptz_view_to_fisheye_mapper_top.sv -----
// Top level of the PTZ view to fisheye mapper: ray forming, view rotation,
// two vectoring CORDICs, radius divider and a rotation CORDIC.
// Depends on ptzfm_pkg, ptzfm_in_if, ptzfm_out_if, ptzfm_cordic_vec, ptzfm_cordic_rot.
// One beat is taken every cycle in which the pipeline advances.
// The three CORDICs and the one-bit-per-stage radius divider set the depth.
// The whole pipeline advances whenever the output register is empty or being read.
// Reset empties the pipeline and loads the registers with their default values.
module ptz_view_to_fisheye_mapper_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ptzfm_pkg::W_CFG_IDX-1:0]     cfg_index,
  input  logic [ptzfm_pkg::W_CFG_DATA-1:0]    cfg_data,
  ptzfm_in_if.sink                            sample,
  ptzfm_out_if.source                         result
);

  localparam int WR  = ptzfm_pkg::W_RAY;
  localparam int WW  = ptzfm_pkg::W_W;
  localparam int WV  = ptzfm_pkg::W_VEC;
  localparam int ZW  = ptzfm_pkg::W_ANG;
  localparam int WT  = ptzfm_pkg::W_ROT;
  localparam int WP  = ptzfm_pkg::W_PQ;
  localparam int DW  = ptzfm_pkg::DIV_W;
  localparam int DS  = ptzfm_pkg::DIV_STEPS;

  // Configuration registers.
  logic [23:0] inv_focal;
  logic [11:0] src_center_x2;
  logic [11:0] src_center_y2;
  logic [10:0] out_radius;
  logic [7:0]  tilt_limit_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_focal      <= ptzfm_pkg::RST_INV_FOCAL;
      src_center_x2  <= ptzfm_pkg::RST_CENTER_X2;
      src_center_y2  <= ptzfm_pkg::RST_CENTER_Y2;
      out_radius     <= ptzfm_pkg::RST_OUT_RADIUS;
      tilt_limit_deg <= ptzfm_pkg::RST_TILT_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptzfm_pkg::REG_INV_FOCAL:  inv_focal      <= cfg_data;
        ptzfm_pkg::REG_CENTER_X2:  src_center_x2  <= cfg_data[11:0];
        ptzfm_pkg::REG_CENTER_Y2:  src_center_y2  <= cfg_data[11:0];
        ptzfm_pkg::REG_OUT_RADIUS: out_radius     <= cfg_data[10:0];
        ptzfm_pkg::REG_TILT_LIMIT: tilt_limit_deg <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic o_vld;

  assign adv          = !o_vld || result.ready;
  assign sample.ready = adv;

  function automatic logic signed [WR-1:0] sat_ray(input logic signed [36:0] p);
    logic signed [36:0] r;
    r = (p + 37'sd256) >>> 9;
    if (r < -37'sd131072) return -18'sd131072;
    else if (r > 37'sd131071) return 18'sd131071;
    else return r[WR-1:0];
  endfunction

  // Stage 1: ray products and view coefficients.
  logic [2:0]         pi_c;
  logic [1:0]         ti_c;
  logic [3:0]         kt;
  logic signed [10:0] c, s, c2, s2;
  logic signed [12:0] d2x, d2y;

  always_comb begin
    pi_c = (int'(sample.pan_index) > ptzfm_pkg::PAN_VIEWS - 1) ?
           3'(ptzfm_pkg::PAN_VIEWS - 1) : sample.pan_index;
    ti_c = (int'(sample.tilt_index) > ptzfm_pkg::TILT_VIEWS - 1) ?
           2'(ptzfm_pkg::TILT_VIEWS - 1) : sample.tilt_index;
    kt   = 4'(ptzfm_pkg::TILT_VIEWS - 1 - int'(ti_c));
    c    = ptzfm_pkg::pan_cos(pi_c);
    s    = ptzfm_pkg::pan_sin(pi_c);
    c2   = ptzfm_pkg::tilt_cos(kt);
    s2   = ptzfm_pkg::tilt_sin(kt);
    d2x  = $signed({1'b0, src_center_x2}) - $signed({2'b00, sample.src_x, 1'b0});
    d2y  = $signed({1'b0, src_center_y2}) - $signed({2'b00, sample.src_y, 1'b0});
  end

  logic               s1_vld;
  logic signed [36:0] s1_px, s1_py, s1_s2k;
  logic signed [20:0] s1_ca, s1_cb, s1_csc, s1_cd, s1_ce, s1_ccc, s1_cg;
  logic [23:0]        s1_pix;

  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else if (adv) s1_vld <= sample.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_px  <= 37'(d2x) * 37'($signed({1'b0, inv_focal}));
      s1_py  <= 37'(d2y) * 37'($signed({1'b0, inv_focal}));
      s1_ca  <= 21'(c) * 21'sd1000;
      s1_cb  <= 21'(s) * 21'(s2);
      s1_csc <= 21'(s) * 21'(c2);
      s1_cd  <= 21'(s) * 21'sd1000;
      s1_ce  <= 21'(c) * 21'(s2);
      s1_ccc <= 21'(c) * 21'(c2);
      s1_cg  <= 21'(c2) * 21'sd1000;
      s1_s2k <= 37'(s2) * 37'sd65536000;
      s1_pix <= sample.pixel;
    end
  end

  // Stage 2: round and saturate the ray to Q1.16.
  logic                s2_vld;
  logic signed [WR-1:0] s2_u, s2_v;
  logic signed [36:0]  s2_s2k;
  logic signed [20:0]  s2_ca, s2_cb, s2_csc, s2_cd, s2_ce, s2_ccc, s2_cg;
  logic [23:0]         s2_pix;

  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else if (adv) s2_vld <= s1_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_u   <= sat_ray(s1_px);
      s2_v   <= sat_ray(s1_py);
      s2_ca  <= s1_ca;
      s2_cb  <= s1_cb;
      s2_csc <= s1_csc;
      s2_cd  <= s1_cd;
      s2_ce  <= s1_ce;
      s2_ccc <= s1_ccc;
      s2_cg  <= s1_cg;
      s2_s2k <= s1_s2k;
      s2_pix <= s1_pix;
    end
  end

  // Stage 3: rotation products.
  logic               s3_vld;
  logic signed [38:0] s3_t1, s3_t2, s3_t4, s3_t5, s3_t7;
  logic signed [20:0] s3_csc, s3_ccc;
  logic signed [36:0] s3_s2k;
  logic [23:0]        s3_pix;

  always_ff @(posedge clk) begin
    if (rst) s3_vld <= 1'b0;
    else if (adv) s3_vld <= s2_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_t1  <= 39'(s2_ca) * 39'(s2_u);
      s3_t2  <= 39'(s2_cb) * 39'(s2_v);
      s3_t4  <= 39'(s2_cd) * 39'(s2_u);
      s3_t5  <= 39'(s2_ce) * 39'(s2_v);
      s3_t7  <= 39'(s2_cg) * 39'(s2_v);
      s3_csc <= s2_csc;
      s3_ccc <= s2_ccc;
      s3_s2k <= s2_s2k;
      s3_pix <= s2_pix;
    end
  end

  // Stage 4: rotated ray sums.
  logic                s4_vld;
  logic signed [WW-1:0] s4_wx, s4_wy, s4_wz;
  logic [23:0]         s4_pix;

  always_ff @(posedge clk) begin
    if (rst) s4_vld <= 1'b0;
    else if (adv) s4_vld <= s3_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_wx  <= WW'(s3_t1) - WW'(s3_t2) - (WW'(s3_csc) <<< 16);
      s4_wy  <= WW'(s3_t4) + WW'(s3_t5) + (WW'(s3_ccc) <<< 16);
      s4_wz  <= WW'(s3_s2k) - WW'(s3_t7);
      s4_pix <= s3_pix;
    end
  end

  // Pan angle and horizontal magnitude.
  logic                 v1_vld;
  logic signed [WV-1:0] v1_mag;
  logic signed [ZW-1:0] v1_ang;
  logic [WW+23:0]       v1_side;

  ptzfm_cordic_vec #(.W(WV), .STEPS(CORDIC_STEPS), .SW(WW + 24)) u_vec_pan (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (s4_vld),
    .x        (WV'(s4_wy)),
    .y        (WV'(s4_wx)),
    .side_in  ({s4_wz, s4_pix}),
    .out_vld  (v1_vld),
    .mag      (v1_mag),
    .ang      (v1_ang),
    .side_out (v1_side)
  );

  // Stages 5 and 6: remove the CORDIC gain in two partial products.
  logic                 s5_vld;
  logic [36:0]          s5_lo, s5_hi;
  logic signed [ZW-1:0] s5_zp;
  logic signed [WW-1:0] s5_wz;
  logic [23:0]          s5_pix;

  always_ff @(posedge clk) begin
    if (rst) s5_vld <= 1'b0;
    else if (adv) s5_vld <= v1_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_lo  <= 37'(v1_mag[20:0]) * 37'(ptzfm_pkg::GAIN_INV);
      s5_hi  <= 37'(v1_mag[41:21]) * 37'(ptzfm_pkg::GAIN_INV);
      s5_zp  <= -v1_ang;
      s5_wz  <= $signed(v1_side[WW+23:24]);
      s5_pix <= v1_side[23:0];
    end
  end

  logic                 s6_vld;
  logic [41:0]          s6_mc;
  logic signed [ZW-1:0] s6_zp;
  logic signed [WW-1:0] s6_wz;
  logic [23:0]          s6_pix;
  logic [57:0]          gsum;

  assign gsum = (58'(s5_hi) << 21) + 58'(s5_lo);

  always_ff @(posedge clk) begin
    if (rst) s6_vld <= 1'b0;
    else if (adv) s6_vld <= s5_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_mc  <= gsum[57:16];
      s6_zp  <= s5_zp;
      s6_wz  <= s5_wz;
      s6_pix <= s5_pix;
    end
  end

  // Elevation angle.
  logic                 v2_vld;
  logic signed [ZW-1:0] v2_ang;
  logic [ZW+23:0]       v2_side;
  logic signed [ZW-1:0] v2_zp;

  ptzfm_cordic_vec #(.W(WV), .STEPS(CORDIC_STEPS), .SW(ZW + 24)) u_vec_tilt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (s6_vld),
    .x        ($signed({2'b00, s6_mc})),
    .y        (WV'(s6_wz)),
    .side_in  ({s6_zp, s6_pix}),
    .out_vld  (v2_vld),
    .mag      (),
    .ang      (v2_ang),
    .side_out (v2_side)
  );

  assign v2_zp = $signed(v2_side[ZW+23:24]);

  // Stage 7: quantize pan to Q9.8 and tilt to Q8.8 degrees.
  logic signed [ZW-1:0] pq_full, tsum;
  logic [15:0]          tq_c;

  always_comb begin
    pq_full = (v2_zp + 26'sd128) >>> 8;
    tsum    = 26'sd23040 + ((v2_ang + 26'sd128) >>> 8);
    priority if (tsum < 26'sd0) tq_c = 16'd0;
    else if (tsum > 26'sd46080) tq_c = 16'd46080;
    else tq_c = tsum[15:0];
  end

  logic                 s7_vld;
  logic signed [WP-1:0] s7_pq;
  logic [15:0]          s7_tq;
  logic                 s7_in;
  logic [23:0]          s7_pix;

  always_ff @(posedge clk) begin
    if (rst) s7_vld <= 1'b0;
    else if (adv) s7_vld <= v2_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_pq  <= pq_full[WP-1:0];
      s7_tq  <= tq_c;
      s7_in  <= tq_c < {tilt_limit_deg, 8'h00};
      s7_pix <= v2_side[23:0];
    end
  end

  // Stage 8 loads the divider with radius times tilt, scaled by 256.
  logic                 dv_vld [DS+1];
  logic [DW-1:0]        dv_dq  [DS+1];
  logic [8:0]           dv_rem [DS+1];
  logic signed [WP-1:0] dv_pq  [DS+1];
  logic                 dv_in  [DS+1];
  logic [23:0]          dv_pix [DS+1];
  logic [8:0]           lim;

  // A zero limit divides as if it were one.
  assign lim = (tilt_limit_deg == 8'd0) ? 9'd1 : {1'b0, tilt_limit_deg};

  always_ff @(posedge clk) begin
    if (rst) dv_vld[0] <= 1'b0;
    else if (adv) dv_vld[0] <= s7_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_dq[0]  <= {27'(out_radius) * 27'(s7_tq), 8'h00};
      dv_rem[0] <= '0;
      dv_pq[0]  <= s7_pq;
      dv_in[0]  <= s7_in;
      dv_pix[0] <= s7_pix;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar j = 0; j < DS; j++) begin : g_div
    logic [9:0] t;
    logic       ge;

    assign t  = {dv_rem[j], dv_dq[j][DW-1]};
    assign ge = t >= {1'b0, lim};

    always_ff @(posedge clk) begin
      if (rst) dv_vld[j+1] <= 1'b0;
      else if (adv) dv_vld[j+1] <= dv_vld[j];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[j+1] <= ge ? 9'(t - {1'b0, lim}) : t[8:0];
        dv_dq[j+1]  <= {dv_dq[j][DW-2:0], ge};
        dv_pq[j+1]  <= dv_pq[j];
        dv_in[j+1]  <= dv_in[j];
        dv_pix[j+1] <= dv_pix[j];
      end
    end
  end

  // Stages 9 and 10: gain compensation of the radius.
  logic [DW-1:0]        rq;
  logic                 s9_vld;
  logic [33:0]          s9_lo;
  logic [32:0]          s9_hi;
  logic signed [WP-1:0] s9_pq;
  logic                 s9_in;
  logic [23:0]          s9_pix;

  assign rq = dv_dq[DS];

  always_ff @(posedge clk) begin
    if (rst) s9_vld <= 1'b0;
    else if (adv) s9_vld <= dv_vld[DS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_lo  <= 34'(rq[17:0]) * 34'(ptzfm_pkg::GAIN_INV);
      s9_hi  <= 33'(rq[DW-1:18]) * 33'(ptzfm_pkg::GAIN_INV);
      s9_pq  <= dv_pq[DS];
      s9_in  <= dv_in[DS];
      s9_pix <= dv_pix[DS];
    end
  end

  logic                 s10_vld;
  logic [34:0]          s10_x0;
  logic signed [WP-1:0] s10_pq;
  logic                 s10_in;
  logic [23:0]          s10_pix;
  logic [50:0]          rsum;

  assign rsum = (51'(s9_hi) << 18) + 51'(s9_lo);

  always_ff @(posedge clk) begin
    if (rst) s10_vld <= 1'b0;
    else if (adv) s10_vld <= s9_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_x0  <= rsum[50:16];
      s10_pq  <= s9_pq;
      s10_in  <= s9_in;
      s10_pix <= s9_pix;
    end
  end

  // Polar to Cartesian in the output circle.
  logic                 r_vld;
  logic signed [WT-1:0] r_x, r_y;
  logic [24:0]          r_side;

  ptzfm_cordic_rot #(.W(WT), .STEPS(CORDIC_STEPS), .SW(25)) u_rot (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (s10_vld),
    .x0       ($signed({3'b000, s10_x0})),
    .ang      ($signed({s10_pq, 8'h00})),
    .side_in  ({s10_in, s10_pix}),
    .out_vld  (r_vld),
    .x_out    (r_x),
    .y_out    (r_y),
    .side_out (r_side)
  );

  // Stage 11: shift to the circle center, round and saturate.
  function automatic logic [11:0] sat_coord(input logic signed [39:0] sum);
    logic signed [39:0] q;
    q = sum >>> 16;
    if (q < 40'sd0) return 12'd0;
    else if (q > 40'sd4095) return 12'd4095;
    else return q[11:0];
  endfunction

  logic signed [39:0] ctr;
  logic [11:0]        o_x, o_y;
  logic               o_in;
  logic [23:0]        o_pix;

  assign ctr = 40'($signed({2'b00, out_radius, 1'b0}) - 14'sd1) <<< 15;

  always_ff @(posedge clk) begin
    if (rst) o_vld <= 1'b0;
    else if (adv) o_vld <= r_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_x   <= sat_coord(40'(r_x) + ctr + 40'sd32768);
      o_y   <= sat_coord(40'(r_y) + ctr + 40'sd32768);
      o_in  <= r_side[24];
      o_pix <= r_side[23:0];
    end
  end

  assign result.valid      = o_vld;
  assign result.dest_x     = o_x;
  assign result.dest_y     = o_y;
  assign result.inside_res = o_in;
  assign result.pixel_out  = o_pix;

endmodule

// ----- dv/tb_ptz_view_to_fisheye_mapper_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for ptz_view_to_fisheye_mapper_top: random and directed pixels,
// a built-in mapping predictor and a scoreboard that checks every result field.
// Depends on ptzfm_pkg, ptzfm_in_if, ptzfm_out_if and the RTL top level.
module tb_ptz_view_to_fisheye_mapper_top;

  localparam int  LAT_WAIT   = 120;
  localparam int  LONG_HOLD  = 400;
  localparam int  CYCLE_CAP  = 500000;
  localparam int  STEPS      = 16;
  localparam logic [2:0] TOP_IDX = 3'd7;

  typedef struct packed {
    logic [2:0]  pan;
    logic [1:0]  tilt;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [23:0] pixel;
  } src_pix_t;

  typedef struct packed {
    logic [11:0] dx;
    logic [11:0] dy;
    logic        in_circ;
    logic [23:0] pixel;
  } map_res_t;

  logic clk, rst, cfg_we;
  logic [ptzfm_pkg::W_CFG_IDX-1:0]  cfg_index;
  logic [ptzfm_pkg::W_CFG_DATA-1:0] cfg_data;

  ptzfm_in_if  pix_in ();
  ptzfm_out_if pix_out ();

  ptz_view_to_fisheye_mapper_top u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sample(pix_in), .result(pix_out)
  );

  // Shadow copy of the configuration registers.
  longint m_inv, m_cx2, m_cy2, m_rad, m_tlim;

  longint vcos[8] = '{1000, 707, 0, -707, -1000, -707, 0, 707};
  longint vsin[8] = '{0, 707, 1000, 707, 0, -707, -1000, -707};
  longint tcos[4] = '{1000, 892, 594, 169};
  longint tsin[4] = '{0, -450, -803, -985};
  longint arctan[STEPS] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

  src_pix_t pending[$];
  map_res_t expected_maps[$];

  int unsigned cycles, mismatches, n_in, n_out, n_inside;
  int hold_req, hold_seen, hold_left, src_gap, snk_gap;
  bit took, quiet;

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint vec_atan(longint x, longint y, output longint mag);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 90 * 65536;
      end else begin
        x = -y; y = t; z = -90 * 65536;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += arctan[i];
      end else begin
        x -= ys; y += xs; z -= arctan[i];
      end
    end
    mag = x < 0 ? 0 : x;
    return z;
  endfunction

  function automatic void rotate(input longint x0, input longint ang, output longint xo,
                                 output longint yo);
    longint x, y, z, xs, ys;
    x = x0; y = 0; z = ang;
    if (z > 90 * 65536) begin
      x = 0; y = x0; z -= 90 * 65536;
    end else if (z < -90 * 65536) begin
      x = 0; y = -x0; z += 90 * 65536;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= arctan[i];
      end else begin
        x += ys; y -= xs; z += arctan[i];
      end
    end
    xo = x;
    yo = y;
  endfunction

  function automatic longint ray(longint center2, longint pos);
    return clampl(((center2 - 2 * pos) * m_inv + 256) >>> 9, -131072, 131071);
  endfunction

  function automatic map_res_t map_pixel(src_pix_t p);
    map_res_t r;
    longint u, v, c, s, c2, s2, wx, wy, wz, m1, m2, mc, zp, zt, pq, tq, lim, rq, cx, cy, ctr;
    int k;
    k = 3 - int'(p.tilt);
    u = ray(m_cx2, longint'(p.x));
    v = ray(m_cy2, longint'(p.y));
    c = vcos[p.pan];
    s = vsin[p.pan];
    c2 = tcos[k];
    s2 = tsin[k];
    wx = 1000 * c * u - s * s2 * v - 65536 * s * c2;
    wy = 1000 * s * u + c * s2 * v + 65536 * c * c2;
    wz = -1000 * c2 * v + 65536000 * s2;
    zp = -vec_atan(wy, wx, m1);
    mc = (m1 * 39797) >>> 16;
    zt = vec_atan(mc, wz, m2);
    pq = (zp + 128) >>> 8;
    tq = clampl(90 * 256 + ((zt + 128) >>> 8), 0, 180 * 256);
    lim = m_tlim != 0 ? m_tlim : 1;
    rq = (m_rad * tq * 256) / lim;
    rotate((rq * 39797) >>> 16, pq * 256, cx, cy);
    ctr = (2 * m_rad - 1) * 32768;
    r.dx = 12'(clampl((ctr + cx + 32768) >>> 16, 0, 4095));
    r.dy = 12'(clampl((ctr + cy + 32768) >>> 16, 0, 4095));
    r.in_circ = tq < m_tlim * 256;
    r.pixel = p.pixel;
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Sender: a new beat goes out at the falling edge once the last one was taken.
  always @(negedge clk) begin
    if (rst) begin
      pix_in.valid <= 1'b0;
    end else if (!pix_in.valid || took) begin
      if (src_gap > 0) begin
        src_gap--;
        pix_in.valid <= 1'b0;
      end else if (pending.size() > 0 && !quiet && $urandom_range(0, 15) == 0) begin
        src_gap = $urandom_range(0, 10);
        pix_in.valid <= 1'b0;
      end else if (pending.size() > 0) begin
        src_pix_t p;
        p = pending.pop_front();
        pix_in.pan_index <= p.pan;
        pix_in.tilt_index <= p.tilt;
        pix_in.src_x <= p.x;
        pix_in.src_y <= p.y;
        pix_in.pixel <= p.pixel;
        pix_in.valid <= 1'b1;
      end else begin
        pix_in.valid <= 1'b0;
      end
    end
    took = 1'b0;
  end

  // Receiver: random stalls plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (rst) begin
      pix_out.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pix_out.ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap--;
      pix_out.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      snk_gap = $urandom_range(0, 10);
      pix_out.ready <= 1'b0;
    end else begin
      pix_out.ready <= 1'b1;
    end
  end

  // Scoreboard and watchdog, sampled at the rising edge.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_maps.size());
      $display("[FAIL] regression broken");
      $finish;
    end
    if (!rst && pix_in.valid && pix_in.ready) begin
      src_pix_t p;
      p.pan = pix_in.pan_index;
      p.tilt = pix_in.tilt_index;
      p.x = pix_in.src_x;
      p.y = pix_in.src_y;
      p.pixel = pix_in.pixel;
      expected_maps.push_back(map_pixel(p));
      n_in++;
      took = 1'b1;
    end
    if (!rst && pix_out.valid && pix_out.ready) begin
      map_res_t e;
      n_out++;
      if (expected_maps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat at cycle %0d", cycles);
      end else begin
        e = expected_maps.pop_front();
        if (e.in_circ) n_inside++;
        if (pix_out.dest_x !== e.dx || pix_out.dest_y !== e.dy ||
            pix_out.inside_res !== e.in_circ || pix_out.pixel_out !== e.pixel) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: exp x=%0d y=%0d in=%0b pix=%h got x=%0d y=%0d in=%0b pix=%h",
                     n_out, e.dx, e.dy, e.in_circ, e.pixel, pix_out.dest_x,
                     pix_out.dest_y, pix_out.inside_res, pix_out.pixel_out);
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ptzfm_pkg::REG_INV_FOCAL:  m_inv = longint'(val);
      ptzfm_pkg::REG_CENTER_X2:  m_cx2 = longint'(val[11:0]);
      ptzfm_pkg::REG_CENTER_Y2:  m_cy2 = longint'(val[11:0]);
      ptzfm_pkg::REG_OUT_RADIUS: m_rad = longint'(val[10:0]);
      ptzfm_pkg::REG_TILT_LIMIT: m_tlim = longint'(val[7:0]);
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending.size() > 0 || pix_in.valid || expected_maps.size() > 0) @(posedge clk);
    repeat (LAT_WAIT) @(posedge clk);
  endtask

  task automatic add_pix(input int pan, input int tilt, input int x, input int y,
                         input logic [23:0] pixel);
    src_pix_t p;
    p.pan = 3'(pan);
    p.tilt = 2'(tilt);
    p.x = 10'(x);
    p.y = 10'(y);
    p.pixel = pixel;
    pending.push_back(p);
  endtask

  task automatic add_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0)
        add_pix($urandom_range(0, 7), $urandom_range(0, 3),
                int'((m_cx2 / 2) + $urandom_range(0, 8) - 4),
                int'((m_cy2 / 2) + $urandom_range(0, 8) - 4),
                24'($urandom));
      else
        add_pix($urandom_range(0, 7), $urandom_range(0, 3), $urandom_range(0, 1023),
                $urandom_range(0, 1023), 24'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix_in.valid = 1'b0;
    pix_in.pan_index = '0;
    pix_in.tilt_index = '0;
    pix_in.src_x = '0;
    pix_in.src_y = '0;
    pix_in.pixel = '0;
    pix_out.ready = 1'b0;
    m_inv = longint'(ptzfm_pkg::RST_INV_FOCAL);
    m_cx2 = longint'(ptzfm_pkg::RST_CENTER_X2);
    m_cy2 = longint'(ptzfm_pkg::RST_CENTER_Y2);
    m_rad = longint'(ptzfm_pkg::RST_OUT_RADIUS);
    m_tlim = longint'(ptzfm_pkg::RST_TILT_LIMIT);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: every pan view and every tilt view, the frame corners and both color extremes.
    for (int pn = 0; pn < 8; pn++) add_pix(pn, pn % 4, 0, 0, 24'h000000);
    for (int t = 0; t < 4; t++) add_pix(7, t, 1023, 1023, 24'hFFFFFF);
    add_pix(0, 3, 1023, 0, 24'hA5A5A5);
    add_pix(4, 0, 0, 1023, 24'h5A5A5A);
    drain();
    // A centered pixel with an even center gives a zero ray in the image plane.
    write_reg(ptzfm_pkg::REG_CENTER_X2, 24'd1022);
    write_reg(ptzfm_pkg::REG_CENTER_Y2, 24'd1022);
    for (int t = 0; t < 4; t++) add_pix(2 * t, t, 511, 511, 24'h123456);
    add_pix(3, 3, 511, 511, 24'hFEDCBA);
    drain();
    // Writes past the register list must be ignored.
    for (logic [2:0] i = 3'(ptzfm_pkg::REG_TILT_LIMIT + 1); i <= TOP_IDX && i != 0; i++)
      write_reg(i, 24'($urandom));

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(ptzfm_pkg::REG_INV_FOCAL, 24'd1);
          write_reg(ptzfm_pkg::REG_CENTER_X2, 24'd0);
          write_reg(ptzfm_pkg::REG_CENTER_Y2, 24'd0);
          write_reg(ptzfm_pkg::REG_OUT_RADIUS, 24'd1);
          write_reg(ptzfm_pkg::REG_TILT_LIMIT, 24'd1);
        end
        1: begin
          write_reg(ptzfm_pkg::REG_INV_FOCAL, 24'hFFFFFF);
          write_reg(ptzfm_pkg::REG_CENTER_X2, 24'd4095);
          write_reg(ptzfm_pkg::REG_CENTER_Y2, 24'd4095);
          write_reg(ptzfm_pkg::REG_OUT_RADIUS, 24'd2047);
          write_reg(ptzfm_pkg::REG_TILT_LIMIT, 24'd180);
        end
        2: begin
          write_reg(ptzfm_pkg::REG_INV_FOCAL, 24'd29183);
          write_reg(ptzfm_pkg::REG_CENTER_X2, 24'd1022);
          write_reg(ptzfm_pkg::REG_CENTER_Y2, 24'd1022);
          write_reg(ptzfm_pkg::REG_OUT_RADIUS, 24'd500);
          write_reg(ptzfm_pkg::REG_TILT_LIMIT, 24'd0);
          hold_req++;
        end
        3: write_reg(ptzfm_pkg::REG_TILT_LIMIT, 24'd255);
        default: begin
          write_reg(ptzfm_pkg::REG_INV_FOCAL, 24'($urandom_range(1, 200000)));
          write_reg(ptzfm_pkg::REG_CENTER_X2, 24'($urandom_range(0, 4095)));
          write_reg(ptzfm_pkg::REG_CENTER_Y2, 24'($urandom_range(0, 4095)));
          write_reg(ptzfm_pkg::REG_OUT_RADIUS, 24'($urandom_range(1, 2047)));
          write_reg(ptzfm_pkg::REG_TILT_LIMIT, 24'($urandom_range(1, 180)));
        end
      endcase
      add_random(200);
      drain();
    end

    write_reg(ptzfm_pkg::REG_INV_FOCAL, ptzfm_pkg::RST_INV_FOCAL);
    write_reg(ptzfm_pkg::REG_CENTER_X2, 24'(ptzfm_pkg::RST_CENTER_X2));
    write_reg(ptzfm_pkg::REG_CENTER_Y2, 24'(ptzfm_pkg::RST_CENTER_Y2));
    write_reg(ptzfm_pkg::REG_OUT_RADIUS, 24'(ptzfm_pkg::RST_OUT_RADIUS));
    write_reg(ptzfm_pkg::REG_TILT_LIMIT, 24'(ptzfm_pkg::RST_TILT_LIMIT));
    quiet = 1'b1;
    add_random(30);
    drain();

    $display("Mapped %0d pixels (%0d inside the circle) over ten register settings;",
             n_in, n_inside);
    $display("%0d beats checked, %0d mismatches, %0d cycles.", n_out, mismatches, cycles);
    if (mismatches == 0 && expected_maps.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
